>>> hw/rtl/rfae_pkg.sv
// Shared types and constants of the rotor flux angle estimator.
package rfae_pkg;

  localparam int CUR_W = 16;
  localparam int SPD_W = 24;
  localparam int CFG_W = 24;
  localparam int IMR_W = 32;
  localparam int ANG_W = 16;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_TR        = 1'd1;

  localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 24'd1678;
  localparam logic [CFG_W-1:0] INV_TR_RST        = 24'd2560;

  localparam logic signed [IMR_W-1:0] IMR_RST = 32'sd1;
  localparam logic signed [IMR_W-1:0] IMR_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [IMR_W-1:0] IMR_MIN = 32'sh8000_0000;

  localparam logic signed [SPD_W-1:0] SPEED_MAX = 24'sh7F_FFFF;
  localparam logic signed [SPD_W-1:0] SPEED_MIN = 24'sh80_0000;

  // Filter coefficient, unsigned Q.24, clamped to one
  localparam int ALPHA_W = 25;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 25'h100_0000;

  // Shared multiplier operands and product
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 31;
  localparam int PROD_W  = 64;

  // round(2^32 / (2*pi)): radians to turn fraction, Q32
  localparam logic [MUL_B_W-1:0] TURN_PER_RAD = 31'd683565276;

  // Divider: 24 quotient bits after an overflow check
  localparam int NMAG_W    = 40;
  localparam int NUM_W     = 56;
  localparam int DEN_W     = 32;
  localparam int QUO_W     = 24;
  localparam int DIV_STEPS = 24;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [QUO_W-1:0] QUO_POS_MAX = 24'd8388607;
  localparam logic [QUO_W-1:0] QUO_NEG_MAX = 24'd8388608;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALPHA_MUL,
    ST_ALPHA_WB,
    ST_FILT_MUL,
    ST_IMR_WB,
    ST_DIV_INIT,
    ST_DIV,
    ST_SLIP_WB,
    ST_SLIP_MUL,
    ST_SLIP_Q,
    ST_SLIP_TURN,
    ST_SLIP_ANG,
    ST_ROT_Q,
    ST_ROT_TURN,
    ST_ROT_ANG,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_TK,
    MUL_FILT,
    MUL_NUM,
    MUL_SLIP_T,
    MUL_ROT_T,
    MUL_TURN
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    logic     alpha_wb;
    logic     imr_wb;
    logic     div_init;
    logic     div_step;
    logic     slip_wb;
    logic     q_wb;
    logic     slip_ang_wb;
    logic     rot_ang_wb;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

>>> hw/rtl/rfae_datapath.sv
// Datapath: configuration, shared multiplier, filter, divider, angle accumulators.
module rfae_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [rfae_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rfae_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic [rfae_pkg::IN_TDATA_W-1:0]     in_data,
  input  rfae_pkg::dp_cmd_t                   cmd,
  output rfae_pkg::dp_status_t                status,
  output logic [rfae_pkg::OUT_TDATA_W-1:0]    out_data,
  output logic                                out_sat
);

  logic [rfae_pkg::CFG_W-1:0] sample_period;
  logic [rfae_pkg::CFG_W-1:0] inv_tr;

  logic signed [rfae_pkg::CUR_W-1:0] iqs;
  logic signed [rfae_pkg::CUR_W-1:0] ids;
  logic signed [rfae_pkg::SPD_W-1:0] wr;

  logic signed [rfae_pkg::MUL_A_W-1:0] mul_a;
  logic signed [rfae_pkg::MUL_B_W-1:0] mul_b;
  logic signed [rfae_pkg::PROD_W-1:0]  mul_prod;
  logic signed [rfae_pkg::PROD_W-1:0]  prod;

  logic [rfae_pkg::ALPHA_W-1:0]        alpha;
  logic signed [rfae_pkg::MUL_A_W-1:0] diff;
  logic signed [rfae_pkg::IMR_W-1:0]   imr;
  logic [rfae_pkg::ANG_W-1:0]          slip_angle;
  logic [rfae_pkg::ANG_W-1:0]          rotor_angle;

  logic [rfae_pkg::DEN_W-1:0]     rem;
  logic [rfae_pkg::DEN_W-1:0]     den;
  logic [rfae_pkg::QUO_W-1:0]     quo;
  logic [rfae_pkg::QUO_W-1:0]     low;
  logic [rfae_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                           div_ovf;
  logic                           imr_zero;
  logic                           num_neg;
  logic                           num_zero;
  logic                           quo_neg;

  logic signed [rfae_pkg::SPD_W-1:0] slip;
  logic signed [rfae_pkg::SPD_W-1:0] sync;
  logic                              slip_sat;
  logic signed [rfae_pkg::IMR_W-1:0] q;

  // Combinational helpers
  logic signed [rfae_pkg::PROD_W-1:0]  alpha_rnd;
  logic [rfae_pkg::PROD_W-9:0]         alpha_full;
  logic [rfae_pkg::ALPHA_W-1:0]        alpha_next;
  logic signed [rfae_pkg::MUL_A_W-1:0] diff_next;
  logic signed [rfae_pkg::PROD_W-1:0]  imr_rnd;
  logic signed [rfae_pkg::PROD_W-25:0] imr_inc;
  logic signed [rfae_pkg::PROD_W-24:0] imr_sum;
  logic signed [rfae_pkg::IMR_W-1:0]   imr_next;
  logic [rfae_pkg::NMAG_W-1:0]         nmag;
  logic [rfae_pkg::NUM_W-1:0]          num_mag;
  logic [rfae_pkg::DEN_W-1:0]          den_next;
  logic [rfae_pkg::DEN_W:0]            shifted;
  logic [rfae_pkg::DEN_W:0]            rem_sub;
  logic                                ge;
  logic signed [rfae_pkg::SPD_W-1:0]   slip_next;
  logic                                sat_next;
  logic signed [rfae_pkg::SPD_W:0]     sync_sum;
  logic signed [rfae_pkg::SPD_W-1:0]   sync_next;
  logic signed [rfae_pkg::PROD_W-1:0]  q_rnd;
  logic signed [rfae_pkg::PROD_W-1:0]  ang_rnd;
  logic [rfae_pkg::ANG_W-1:0]          ang_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= rfae_pkg::SAMPLE_PERIOD_RST;
      inv_tr        <= rfae_pkg::INV_TR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rfae_pkg::REG_SAMPLE_PERIOD: sample_period <= cfg_wr_data;
        rfae_pkg::REG_INV_TR:        inv_tr        <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      rfae_pkg::MUL_TK: begin
        mul_a = $signed({9'b0, sample_period});
        mul_b = $signed({7'b0, inv_tr});
      end
      rfae_pkg::MUL_FILT: begin
        mul_a = diff;
        mul_b = $signed({6'b0, alpha});
      end
      rfae_pkg::MUL_NUM: begin
        mul_a = rfae_pkg::MUL_A_W'(iqs);
        mul_b = $signed({7'b0, inv_tr});
      end
      rfae_pkg::MUL_SLIP_T: begin
        mul_a = rfae_pkg::MUL_A_W'(slip);
        mul_b = $signed({7'b0, sample_period});
      end
      rfae_pkg::MUL_ROT_T: begin
        mul_a = rfae_pkg::MUL_A_W'(wr);
        mul_b = $signed({7'b0, sample_period});
      end
      rfae_pkg::MUL_TURN: begin
        mul_a = rfae_pkg::MUL_A_W'(q);
        mul_b = $signed(rfae_pkg::TURN_PER_RAD);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_prod = rfae_pkg::PROD_W'(mul_a) * rfae_pkg::PROD_W'(mul_b);

  // Filter coefficient and error term
  always_comb begin
    alpha_rnd  = prod + 64'sd128;
    alpha_full = alpha_rnd[rfae_pkg::PROD_W-1:8];
    if (alpha_full > (rfae_pkg::PROD_W - 8)'(rfae_pkg::ALPHA_ONE)) begin
      alpha_next = rfae_pkg::ALPHA_ONE;
    end else begin
      alpha_next = alpha_full[rfae_pkg::ALPHA_W-1:0];
    end
    diff_next = $signed({ids[rfae_pkg::CUR_W-1], ids, 16'b0}) - $signed({imr[rfae_pkg::IMR_W-1], imr});
  end

  // Magnetizing current update, saturated to 32 bits
  always_comb begin
    imr_rnd = prod + 64'sd8388608;
    imr_inc = $signed(imr_rnd[rfae_pkg::PROD_W-1:24]);
    imr_sum = (rfae_pkg::PROD_W - 23)'(imr) + (rfae_pkg::PROD_W - 23)'(imr_inc);
    if (imr_sum > (rfae_pkg::PROD_W - 23)'(rfae_pkg::IMR_MAX)) begin
      imr_next = rfae_pkg::IMR_MAX;
    end else if (imr_sum < (rfae_pkg::PROD_W - 23)'(rfae_pkg::IMR_MIN)) begin
      imr_next = rfae_pkg::IMR_MIN;
    end else begin
      imr_next = imr_sum[rfae_pkg::IMR_W-1:0];
    end
  end

  // Divider set-up and one restoring step
  always_comb begin
    nmag = prod[rfae_pkg::PROD_W-1] ? rfae_pkg::NMAG_W'(-prod[rfae_pkg::NMAG_W-1:0])
                                    : prod[rfae_pkg::NMAG_W-1:0];
    num_mag  = {nmag, 16'b0};
    den_next = imr[rfae_pkg::IMR_W-1] ? (~imr + 32'd1) : imr;
    shifted  = {rem, low[rfae_pkg::QUO_W-1]};
    ge       = shifted >= {1'b0, den};
    rem_sub  = shifted - {1'b0, den};
  end

  // Slip quotient sign, clamp and synchronous speed
  always_comb begin
    sat_next = 1'b0;
    priority if (imr_zero) begin
      if (num_zero) begin
        slip_next = '0;
      end else begin
        slip_next = num_neg ? rfae_pkg::SPEED_MIN : rfae_pkg::SPEED_MAX;
        sat_next  = 1'b1;
      end
    end else if (div_ovf) begin
      slip_next = quo_neg ? rfae_pkg::SPEED_MIN : rfae_pkg::SPEED_MAX;
      sat_next  = 1'b1;
    end else if (quo_neg) begin
      if (quo > rfae_pkg::QUO_NEG_MAX) begin
        slip_next = rfae_pkg::SPEED_MIN;
        sat_next  = 1'b1;
      end else begin
        slip_next = $signed(~quo + 24'd1);
      end
    end else begin
      if (quo > rfae_pkg::QUO_POS_MAX) begin
        slip_next = rfae_pkg::SPEED_MAX;
        sat_next  = 1'b1;
      end else begin
        slip_next = $signed(quo);
      end
    end
    sync_sum = (rfae_pkg::SPD_W + 1)'(slip_next) + (rfae_pkg::SPD_W + 1)'(wr);
    if (sync_sum > (rfae_pkg::SPD_W + 1)'(rfae_pkg::SPEED_MAX)) begin
      sync_next = rfae_pkg::SPEED_MAX;
    end else if (sync_sum < (rfae_pkg::SPD_W + 1)'(rfae_pkg::SPEED_MIN)) begin
      sync_next = rfae_pkg::SPEED_MIN;
    end else begin
      sync_next = sync_sum[rfae_pkg::SPD_W-1:0];
    end
  end

  // Angle step rounding
  always_comb begin
    q_rnd   = prod + 64'sd32768;
    ang_rnd = prod + 64'sd2147483648;
    ang_inc = ang_rnd[47:32];
  end

  assign status.div_done = (div_cnt == rfae_pkg::DIV_LAST);

  always_ff @(posedge clk) begin
    prod <= mul_prod;
    if (cmd.load_in) begin
      iqs <= $signed(in_data[15:0]);
      ids <= $signed(in_data[31:16]);
      wr  <= $signed(in_data[55:32]);
    end
    if (cmd.alpha_wb) begin
      alpha <= alpha_next;
      diff  <= diff_next;
    end
    if (cmd.div_init) begin
      rem      <= num_mag[rfae_pkg::NUM_W-1:rfae_pkg::QUO_W];
      low      <= num_mag[rfae_pkg::QUO_W-1:0];
      den      <= den_next;
      quo      <= '0;
      div_ovf  <= num_mag[rfae_pkg::NUM_W-1:rfae_pkg::QUO_W] >= den_next;
      imr_zero <= (imr == '0);
      num_neg  <= prod[rfae_pkg::PROD_W-1];
      num_zero <= (prod == '0);
      quo_neg  <= prod[rfae_pkg::PROD_W-1] ^ imr[rfae_pkg::IMR_W-1];
    end else if (cmd.div_step) begin
      rem <= ge ? rem_sub[rfae_pkg::DEN_W-1:0] : shifted[rfae_pkg::DEN_W-1:0];
      quo <= {quo[rfae_pkg::QUO_W-2:0], ge};
      low <= {low[rfae_pkg::QUO_W-2:0], 1'b0};
    end
    if (cmd.slip_wb) begin
      slip     <= slip_next;
      sync     <= sync_next;
      slip_sat <= sat_next;
    end
    if (cmd.q_wb) begin
      q <= q_rnd[47:16];
    end
    if (cmd.out_load) begin
      out_data <= {imr[rfae_pkg::IMR_W-1:16], sync, slip_angle + rotor_angle};
      out_sat  <= slip_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + rfae_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      imr         <= rfae_pkg::IMR_RST;
      slip_angle  <= '0;
      rotor_angle <= '0;
    end else begin
      if (cmd.imr_wb) begin
        imr <= imr_next;
      end
      if (cmd.slip_ang_wb) begin
        slip_angle <= slip_angle + ang_inc;
      end
      if (cmd.rot_ang_wb) begin
        rotor_angle <= rotor_angle + ang_inc;
      end
    end
  end

endmodule

>>> hw/rtl/rfae_controller.sv
// Controller: sequences one word through the datapath and owns the handshakes.
module rfae_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  rfae_pkg::dp_status_t status,
  output rfae_pkg::dp_cmd_t    cmd
);

  rfae_pkg::state_t state;
  rfae_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rfae_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign s_tready = (state == rfae_pkg::ST_IDLE);

  always_comb begin
    cmd         = '0;
    state_next  = state;
    unique case (state)
      rfae_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = rfae_pkg::ST_ALPHA_MUL;
        end
      end
      rfae_pkg::ST_ALPHA_MUL: begin
        cmd.mul_sel = rfae_pkg::MUL_TK;
        state_next  = rfae_pkg::ST_ALPHA_WB;
      end
      rfae_pkg::ST_ALPHA_WB: begin
        cmd.alpha_wb = 1'b1;
        state_next   = rfae_pkg::ST_FILT_MUL;
      end
      rfae_pkg::ST_FILT_MUL: begin
        cmd.mul_sel = rfae_pkg::MUL_FILT;
        state_next  = rfae_pkg::ST_IMR_WB;
      end
      rfae_pkg::ST_IMR_WB: begin
        cmd.imr_wb  = 1'b1;
        cmd.mul_sel = rfae_pkg::MUL_NUM;
        state_next  = rfae_pkg::ST_DIV_INIT;
      end
      rfae_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = rfae_pkg::ST_DIV;
      end
      rfae_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = rfae_pkg::ST_SLIP_WB;
        end
      end
      rfae_pkg::ST_SLIP_WB: begin
        cmd.slip_wb = 1'b1;
        state_next  = rfae_pkg::ST_SLIP_MUL;
      end
      rfae_pkg::ST_SLIP_MUL: begin
        cmd.mul_sel = rfae_pkg::MUL_SLIP_T;
        state_next  = rfae_pkg::ST_SLIP_Q;
      end
      rfae_pkg::ST_SLIP_Q: begin
        cmd.q_wb   = 1'b1;
        state_next = rfae_pkg::ST_SLIP_TURN;
      end
      rfae_pkg::ST_SLIP_TURN: begin
        cmd.mul_sel = rfae_pkg::MUL_TURN;
        state_next  = rfae_pkg::ST_SLIP_ANG;
      end
      rfae_pkg::ST_SLIP_ANG: begin
        cmd.slip_ang_wb = 1'b1;
        cmd.mul_sel     = rfae_pkg::MUL_ROT_T;
        state_next      = rfae_pkg::ST_ROT_Q;
      end
      rfae_pkg::ST_ROT_Q: begin
        cmd.q_wb   = 1'b1;
        state_next = rfae_pkg::ST_ROT_TURN;
      end
      rfae_pkg::ST_ROT_TURN: begin
        cmd.mul_sel = rfae_pkg::MUL_TURN;
        state_next  = rfae_pkg::ST_ROT_ANG;
      end
      rfae_pkg::ST_ROT_ANG: begin
        cmd.rot_ang_wb = 1'b1;
        state_next     = rfae_pkg::ST_DONE;
      end
      rfae_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = rfae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rfae_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/rotor_flux_angle_estimator.sv
// Top level of the rotor flux angle estimator (indirect field-oriented current model).
//
// Usage: send one word per PWM period on the slave stream (torque current, flux
// current, rotor speed); one result word comes back on the master stream with
// the flux angle, synchronous speed, filtered magnetizing current and the slip
// saturation flag.
// The 24-step restoring divider for the slip quotient takes most of the time spent
// on a word; the rest is the single shared 33x31 multiplier visited once per
// product.
// s_tready is high only while the block waits for a word; the block works on
// one word at a time.
// Stall: a finished result sits in the output register until m_tready; the
// block already takes the next word, and completes it as far as the output
// stage, where it waits for the register to free.
// Reset (rst, synchronous): registers return to their defaults, magnetizing
// current to its smallest positive value, both angles to zero, streams empty.
// Configuration: write sample_period (index 0) or inverse_rotor_time_constant
// (index 1) through cfg_wr_en only while no word is in flight.
module rotor_flux_angle_estimator (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_wr_en,
  input  logic [rfae_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rfae_pkg::CFG_W-1:0]          cfg_wr_data,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // from bit 0: torque_current[15:0], flux_current[31:16], rotor_speed[55:32]
  input  logic [rfae_pkg::IN_TDATA_W-1:0]     s_tdata,
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // from bit 0: flux_angle[15:0], synchronous_speed[39:16],
  // magnetizing_current_out[55:40]
  output logic [rfae_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // bit 0: slip_saturated
  output logic                                m_tuser
);

  rfae_pkg::dp_cmd_t    cmd;
  rfae_pkg::dp_status_t status;

  // Sequence the word and run the handshakes
  rfae_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold configuration and state, do the arithmetic, drive the result payload
  rfae_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_data    (m_tdata),
    .out_sat     (m_tuser)
  );

endmodule

>>> hw/rtl/rfae_checker.sv
// Port-level checks of the rotor flux angle estimator, bound to the top level.
module rfae_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [rfae_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input logic                                m_tuser
);

  // Come out of reset empty and ready for a word
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("block not empty after reset");

  // One word in flight: take nothing right after a word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word taken while one is in flight");

  // A new result only comes out of a busy block
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a word being worked on");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind rotor_flux_angle_estimator rfae_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> verif/tb_rotor_flux_angle_estimator.sv
// Self-checking testbench for the rotor flux angle estimator: directed table, random phases.
`timescale 1ns / 100ps

module tb_rotor_flux_angle_estimator;

  // Input word, last field in the lowest bits of s_tdata
  typedef struct packed {
    logic signed [rfae_pkg::SPD_W-1:0] rotor_speed;
    logic signed [rfae_pkg::CUR_W-1:0] flux_current;
    logic signed [rfae_pkg::CUR_W-1:0] torque_current;
  } flux_word_t;

  // Result word as {m_tuser, m_tdata}
  typedef struct packed {
    logic                              slip_saturated;
    logic signed [rfae_pkg::CUR_W-1:0] magnetizing_current_out;
    logic signed [rfae_pkg::SPD_W-1:0] synchronous_speed;
    logic [rfae_pkg::ANG_W-1:0]        flux_angle;
  } flux_res_t;

  // One line of the directed table: either a register setting or a word.
  // Where typed is set, speed, current and flag come from the row; the angle
  // is accumulated state and always comes from the angle model.
  typedef struct {
    bit                         is_setting;
    logic [rfae_pkg::CFG_W-1:0] period;
    logic [rfae_pkg::CFG_W-1:0] inv_tr;
    flux_word_t                 word;
    bit                         typed;
    flux_res_t                  typed_res;
  } stim_row_t;

  localparam int  RANDOM_PHASES   = 8;
  localparam int  WORDS_PER_PHASE = 162;
  localparam int  PRESSURE_CYCLES = 400;
  localparam int  PRESSURE_AFTER  = 200;
  localparam int  WATCHDOG_LIMIT  = 5000;
  localparam int  DRAIN_TAIL      = 60;
  localparam longint ALPHA_CAP    = longint'(rfae_pkg::ALPHA_ONE);

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_wr_en = 1'b0;
  logic [rfae_pkg::CFG_INDEX_W-1:0] cfg_index = rfae_pkg::REG_SAMPLE_PERIOD;
  logic [rfae_pkg::CFG_W-1:0]       cfg_wr_data = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [rfae_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [rfae_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tuser;

  // Model state: registers, filter and both angle accumulators
  logic [rfae_pkg::CFG_W-1:0]        cfg_period = rfae_pkg::SAMPLE_PERIOD_RST;
  logic [rfae_pkg::CFG_W-1:0]        cfg_inv_tr = rfae_pkg::INV_TR_RST;
  logic signed [rfae_pkg::IMR_W-1:0] mag_cur    = rfae_pkg::IMR_RST;
  logic [rfae_pkg::ANG_W-1:0]        slip_ang   = '0;
  logic [rfae_pkg::ANG_W-1:0]        rot_ang    = '0;

  flux_res_t flux_results_due[$];
  stim_row_t directed_rows[$];

  int words_sent;
  int results_seen;
  int mismatches;
  int clamped_slips;
  int zero_imr_hits;
  int settings_applied;
  int quiet_cycles;
  bit pressure_done;

  rotor_flux_angle_estimator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Angle and filter model
  // ---------------------------------------------------------------------------

  // Divide by 2^n rounding to nearest, ties upward
  function automatic longint rnd_shift(input longint x, input int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // Turn-fraction increment for one period at the given Q16.8 speed
  function automatic logic [rfae_pkg::ANG_W-1:0] turn_step(input longint speed);
    longint q;
    longint inc;
    q   = rnd_shift(speed * longint'(cfg_period), 16);
    inc = rnd_shift(q * longint'(rfae_pkg::TURN_PER_RAD), 32);
    return inc[rfae_pkg::ANG_W-1:0];
  endfunction

  // Advance filter and angles by one word; return the result it should give
  function automatic flux_res_t advance_flux_model(input flux_word_t w);
    longint    iqs;
    longint    ids;
    longint    wr;
    longint    alpha;
    longint    imr;
    longint    num;
    longint    slip;
    longint    sync;
    flux_res_t r;
    iqs = longint'(w.torque_current);
    ids = longint'(w.flux_current);
    wr  = longint'(w.rotor_speed);
    r.slip_saturated = 1'b0;

    // Filter coefficient, never above one
    alpha = rnd_shift(longint'(cfg_period) * longint'(cfg_inv_tr), 8);
    if (alpha > ALPHA_CAP) alpha = ALPHA_CAP;

    imr = longint'(mag_cur);
    imr = imr + rnd_shift(alpha * (ids * 65536 - imr), 24);
    if (imr > longint'(rfae_pkg::IMR_MAX)) imr = longint'(rfae_pkg::IMR_MAX);
    if (imr < longint'(rfae_pkg::IMR_MIN)) imr = longint'(rfae_pkg::IMR_MIN);
    mag_cur = imr[rfae_pkg::IMR_W-1:0];

    // Slip quotient; a zero divisor pins it to the rail of the numerator's sign, or to zero with a zero numerator
    num = iqs * longint'(cfg_inv_tr) * 65536;
    if (imr == 0) begin
      zero_imr_hits++;
      if (num > 0) slip = longint'(rfae_pkg::SPEED_MAX);
      else if (num < 0) slip = longint'(rfae_pkg::SPEED_MIN);
      else slip = 0;
      r.slip_saturated = (num != 0);
    end else begin
      slip = num / imr;
      if (slip > longint'(rfae_pkg::SPEED_MAX)) begin
        slip = longint'(rfae_pkg::SPEED_MAX);
        r.slip_saturated = 1'b1;
      end else if (slip < longint'(rfae_pkg::SPEED_MIN)) begin
        slip = longint'(rfae_pkg::SPEED_MIN);
        r.slip_saturated = 1'b1;
      end
    end

    // Synchronous speed saturates silently
    sync = slip + wr;
    if (sync > longint'(rfae_pkg::SPEED_MAX)) sync = longint'(rfae_pkg::SPEED_MAX);
    if (sync < longint'(rfae_pkg::SPEED_MIN)) sync = longint'(rfae_pkg::SPEED_MIN);

    slip_ang = slip_ang + turn_step(slip);
    rot_ang  = rot_ang + turn_step(wr);

    r.flux_angle              = slip_ang + rot_ang;
    r.synchronous_speed       = sync[rfae_pkg::SPD_W-1:0];
    r.magnetizing_current_out = 16'(imr >>> 16);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------

  function automatic stim_row_t word_row(input int iqs, input int ids, input int wr);
    stim_row_t r;
    r.is_setting          = 1'b0;
    r.period              = '0;
    r.inv_tr              = '0;
    r.word.torque_current = 16'(iqs);
    r.word.flux_current   = 16'(ids);
    r.word.rotor_speed    = 24'(wr);
    r.typed               = 1'b0;
    r.typed_res           = '0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input int iqs, input int ids, input int wr,
                                            input int sync, input int imr_out, input bit sat);
    stim_row_t r;
    r = word_row(iqs, ids, wr);
    r.typed                             = 1'b1;
    r.typed_res.synchronous_speed       = 24'(sync);
    r.typed_res.magnetizing_current_out = 16'(imr_out);
    r.typed_res.slip_saturated          = sat;
    return r;
  endfunction

  function automatic stim_row_t setting_row(input int period, input int inv_tr);
    stim_row_t r;
    r = word_row(0, 0, 0);
    r.is_setting = 1'b1;
    r.period     = 24'(period);
    r.inv_tr     = 24'(inv_tr);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short pauses, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 80))
                                       : int'($urandom_range(1, 3));
  endfunction

  // Three words in four follow a steady operating point; the rest is noise
  function automatic flux_word_t pick_drive_word(input int flux_base);
    flux_word_t w;
    int         amp;
    int         sel;
    amp = (flux_base < 0) ? -flux_base : flux_base;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      w.flux_current   = 16'(flux_base + int'($urandom_range(0, 32)) - 16);
      w.torque_current = 16'(int'($urandom_range(0, 8 * amp)) - 4 * amp);
      w.rotor_speed    = 24'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    end else begin
      w.torque_current = 16'($urandom);
      w.flux_current   = 16'($urandom);
      w.rotor_speed    = 24'($urandom);
      // drop the flux outright so a full-strength filter lands on zero
      if (sel >= 93) w.flux_current = '0;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until taken, then queue what it should produce
  task automatic send_word(input flux_word_t w, input bit typed, input flux_res_t typed_res);
    flux_res_t want;
    s_tdata  <= w;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = advance_flux_model(w);
    if (typed) begin
      want.synchronous_speed       = typed_res.synchronous_speed;
      want.magnetizing_current_out = typed_res.magnetizing_current_out;
      want.slip_saturated          = typed_res.slip_saturated;
    end
    flux_results_due.push_back(want);
    words_sent++;
  endtask

  task automatic sender_pause(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drain, then write both registers, one per cycle
  task automatic set_config(input logic [rfae_pkg::CFG_W-1:0] period,
                            input logic [rfae_pkg::CFG_W-1:0] inv_tr);
    s_tvalid <= 1'b0;
    while (flux_results_due.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= rfae_pkg::REG_SAMPLE_PERIOD;
    cfg_wr_data <= period;
    @(posedge clk);
    cfg_index   <= rfae_pkg::REG_INV_TR;
    cfg_wr_data <= inv_tr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    cfg_period = period;
    cfg_inv_tr = inv_tr;
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    stim_row_t                  row;
    logic [rfae_pkg::CFG_W-1:0] period;
    logic [rfae_pkg::CFG_W-1:0] inv_tr;
    int                         flux_base;
    bit                         steady;

    // After reset: the filter sits at its smallest positive value, so any
    // torque current throws the slip onto a rail.
    directed_rows.push_back(checked_row(0, 0, 0, 0, 0, 1'b0));
    directed_rows.push_back(checked_row(1, 0, 0, 8388607, 0, 1'b1));
    directed_rows.push_back(checked_row(-1, 0, 0, -8388608, 0, 1'b1));
    directed_rows.push_back(word_row(32767, 32767, 8388607));
    directed_rows.push_back(word_row(-32768, -32768, -8388608));
    // Coefficient above one: clamp to one, so the filter jumps to the flux
    // current and reaches exactly zero with zero flux.
    directed_rows.push_back(setting_row(16777215, 16777215));
    directed_rows.push_back(checked_row(0, 0, 0, 0, 0, 1'b0));
    directed_rows.push_back(checked_row(100, 0, 8388607, 8388607, 0, 1'b1));
    directed_rows.push_back(checked_row(-100, 0, -8388608, -8388608, 0, 1'b1));
    directed_rows.push_back(checked_row(0, -32768, 0, 0, -32768, 1'b0));
    directed_rows.push_back(word_row(-32768, 32767, 8388607));
    directed_rows.push_back(word_row(5, 32767, 0));
    // Zero inverse time constant: filter frozen, slip zero
    directed_rows.push_back(setting_row(16777215, 0));
    directed_rows.push_back(checked_row(32767, 100, 1000, 1000, 32767, 1'b0));
    directed_rows.push_back(checked_row(-32768, -32768, -8388608, -8388608, 32767, 1'b0));
    // Zero period: filter and angles frozen
    directed_rows.push_back(setting_row(0, 1));
    directed_rows.push_back(word_row(-32768, 0, 12345));
    directed_rows.push_back(word_row(32767, 32767, -1));
    // Smallest settings; alternating bit patterns
    directed_rows.push_back(setting_row(1, 1));
    directed_rows.push_back(word_row(21845, -21846, 5592405));
    directed_rows.push_back(word_row(-21846, 21845, -5592406));
    // Back to the defaults: a short steady ramp at one ampere of flux
    directed_rows.push_back(setting_row(int'(rfae_pkg::SAMPLE_PERIOD_RST),
                                        int'(rfae_pkg::INV_TR_RST)));
    directed_rows.push_back(word_row(512, 256, 31416));
    directed_rows.push_back(word_row(512, 256, 31416));
    directed_rows.push_back(word_row(512, 256, 31416));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_setting) set_config(row.period, row.inv_tr);
      else send_word(row.word, row.typed, row.typed_res);
    end

    // Random phases: each picks a setting and a flux operating point, with
    // extremes of both registers among them.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          period = 24'($urandom_range(800, 6000));
          inv_tr = 24'($urandom_range(256, 25600));
        end
        1: begin
          period = (ph < 4) ? 24'd1 : 24'hFF_FFFF;
          inv_tr = 24'($urandom_range(256, 25600));
        end
        2: begin
          period = 24'($urandom_range(1, 24'hFF_FFFF));
          inv_tr = 24'($urandom_range(1, 24'hFF_FFFF));
        end
        default: begin
          period = 24'($urandom_range(800, 6000));
          inv_tr = (ph < 4) ? 24'd1 : 24'hFF_FFFF;
        end
      endcase
      set_config(period, inv_tr);
      flux_base = int'($urandom_range(64, 2560));
      if ($urandom_range(0, 3) == 0) flux_base = -flux_base;
      // one phase runs back to back with no sender pauses
      steady = (ph == 2);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(pick_drive_word(flux_base), 1'b0, '0);
        if (!steady && $urandom_range(0, 1) == 0) sender_pause(gap_len());
      end
    end

    s_tvalid <= 1'b0;
    while (flux_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("covered %0d words under %0d register settings, %0d with the slip clamped",
             words_sent, settings_applied, clamped_slips);
    $display("magnetizing current hit zero %0d times; output held off %0d cycles once",
             zero_imr_hits, PRESSURE_CYCLES);
    if (mismatches == 0) begin
      $display("rotor_flux_angle_estimator verification clean");
    end else begin
      $display("rotor_flux_angle_estimator verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, with one long hold-off once the run is
  // under way so the block fills up and refuses input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        m_tready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 150 : 20)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  // Compare each taken result with the oldest outstanding expectation
  always @(posedge clk) begin : result_check
    flux_res_t got;
    flux_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      results_seen++;
      if (flux_results_due.size() == 0) begin
        $error("result word with nothing outstanding: %h", got);
        mismatches++;
      end else begin
        want = flux_results_due.pop_front();
        if (want.slip_saturated) clamped_slips++;
        if (got.flux_angle !== want.flux_angle) begin
          $error("flux_angle expected %0d got %0d", want.flux_angle, got.flux_angle);
          mismatches++;
        end
        if (got.synchronous_speed !== want.synchronous_speed) begin
          $error("synchronous_speed expected %0d got %0d",
                 want.synchronous_speed, got.synchronous_speed);
          mismatches++;
        end
        if (got.magnetizing_current_out !== want.magnetizing_current_out) begin
          $error("magnetizing_current_out expected %0d got %0d",
                 want.magnetizing_current_out, got.magnetizing_current_out);
          mismatches++;
        end
        if (got.slip_saturated !== want.slip_saturated) begin
          $error("slip_saturated expected %0d got %0d",
                 want.slip_saturated, got.slip_saturated);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timed out with %0d results outstanding", flux_results_due.size());
      $display("rotor_flux_angle_estimator verification failed");
      $finish;
    end
  end

endmodule
